// ----- rtl/tlsg_pkg.sv -----
`default_nettype none

package tlsg_pkg;

  // fixed field widths of the channels and the register port
  localparam int unsigned FIELD_W    = 16;
  localparam int unsigned RADIUS_W   = 8;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // register select bit of paddr and register codes
  localparam int unsigned REG_SEL_BIT = 2;
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 16'd480;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 16'd800;

  // request command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // circle step limit is r*707/1000 + 1
  localparam int unsigned LimitNum = 707;
  localparam int unsigned LimitDen = 1000;
  localparam int unsigned LIMIT_DEPTH = 256;

  typedef logic [RADIUS_W-1:0] limit_tbl_t [LIMIT_DEPTH];

  function automatic limit_tbl_t build_limit_table();
    limit_tbl_t tbl;
    for (int unsigned r = 0; r < LIMIT_DEPTH; r++) begin
      tbl[r] = RADIUS_W'((r * LimitNum) / LimitDen + 1);
    end
    return tbl;
  endfunction

  localparam limit_tbl_t LIMIT_TABLE = build_limit_table();

  // span order within one circle stamp
  typedef enum logic [4:0] {
    PH_CENTRE   = 5'b00001,
    PH_STEP     = 5'b00010,
    PH_OUTER_DN = 5'b00100,
    PH_INNER_UP = 5'b01000,
    PH_INNER_DN = 5'b10000
  } phase_e;

  typedef struct packed {
    logic                cmd;
    logic [FIELD_W-1:0]  start_x;
    logic [FIELD_W-1:0]  start_y;
    logic [FIELD_W-1:0]  end_x;
    logic [FIELD_W-1:0]  end_y;
    logic [RADIUS_W-1:0] brush_radius;
    logic [FIELD_W-1:0]  pen_color;
  } tlsg_req_t;

  typedef struct packed {
    logic               span_valid;
    logic [FIELD_W-1:0] span_left;
    logic [FIELD_W-1:0] span_right;
    logic [FIELD_W-1:0] span_row;
    logic [FIELD_W-1:0] span_color;
    logic               last_span;
    logic               load_accepted;
    logic               busy_res;
  } tlsg_res_t;

endpackage

`default_nettype wire

// ----- rtl/tlsg_if.sv -----
`default_nettype none

// request channel
interface tlsg_req_if;
  logic                 valid;
  logic                 ready;
  tlsg_pkg::tlsg_req_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// result channel
interface tlsg_res_if;
  logic                 valid;
  logic                 ready;
  tlsg_pkg::tlsg_res_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/thick_line_span_generator.sv -----
// channel   dir  handshake       request / result
// req_i     in   valid/ready     load (end points, radius, colour) or tick
// res_o     out  valid/ready     one span, or load status, per request
// apb       in   psel/penable    screen_width at 0x0, screen_height at 0x4
//
// one request accepted per cycle while the result is not stalled; every request gives exactly one result
// an accepted request passes the state update stage, then the clamp stage, before its result appears
// the per-tick circle and line step is one pass over incremental squares and errors
// rst_ni clears the walk, both pipeline valids and loads the screen size 480 x 800
// a stalled result holds in the output register while one more request is taken

`default_nettype none

module thick_line_span_generator #(
  parameter int unsigned COORD_BITS  = 16,
  parameter int unsigned RADIUS_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  tlsg_req_if.sink                            req_i,
  tlsg_res_if.source                          res_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tlsg_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [tlsg_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [tlsg_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned RB   = RADIUS_BITS;
  localparam int unsigned SQ_W = 2 * RB;
  localparam int unsigned CW   = tlsg_pkg::CFG_W;

  // configuration registers
  logic [CW-1:0] width_q, height_q;

  // walk state
  logic                 active_q, active_d;
  tlsg_pkg::phase_e     phase_q, phase_d;
  logic [CB-1:0]        pos_col_q, pos_col_d, pos_row_q, pos_row_d;
  logic [CB-1:0]        err_col_q, err_col_d, err_row_q, err_row_d;
  logic [CB-1:0]        adc_q, adc_d, adr_q, adr_d, md_q, md_d;
  logic                 dec_col_q, dec_col_d, dec_row_q, dec_row_d;
  logic [CB-1:0]        slack_col_q, slack_row_q;
  logic [CB:0]          stamps_q, stamps_d;
  logic [RB-1:0]        step_q, step_d, half_q, half_d, lim_q, lim_d;
  logic [RB-1:0]        radius_q, radius_d;
  logic [SQ_W-1:0]      rsq_q, rsq_d, sq_i_q, sq_i_d, sq_x_q, sq_x_d;
  logic [SQ_W:0]        sqlim_q;
  logic [CW-1:0]        color_q, color_d;

  // first stage: raw span before clamping
  logic                 s1_valid_q;
  logic [CB-1:0]        s1_x_q, s1_y_q, s1_len_q;
  logic [CW-1:0]        s1_color_q;
  logic                 s1_last_q, s1_load_ok_q, s1_busy_q;
  logic [CB-1:0]        nx_x, nx_y, nx_len;
  logic                 nx_last, nx_load_ok, nx_busy;

  // output register
  logic                 out_valid_q;
  tlsg_pkg::tlsg_res_t  out_q, out_d;

  logic adv, acc;

  // handshake: stage one may fill while a finished result waits
  assign adv         = !out_valid_q || res_o.ready;
  assign req_i.ready = !s1_valid_q || adv;
  assign acc         = req_i.valid && req_i.ready;

  // load fields
  logic [CB-1:0] sx, sy, ex, ey, r_ext, adc_ld, adr_ld, md_ld;
  logic [RB-1:0] r_in;
  logic          ld_ok;

  assign sx    = req_i.data.start_x[CB-1:0];
  assign sy    = req_i.data.start_y[CB-1:0];
  assign ex    = req_i.data.end_x[CB-1:0];
  assign ey    = req_i.data.end_y[CB-1:0];
  assign r_in  = req_i.data.brush_radius[RB-1:0];
  assign r_ext = CB'(r_in);
  assign ld_ok = (sx >= r_ext) && (sy >= r_ext) && (ex >= r_ext) && (ey >= r_ext);
  assign adc_ld = (ex > sx) ? ex - sx : sx - ex;
  assign adr_ld = (ey > sy) ? ey - sy : sy - ey;
  assign md_ld  = (adc_ld > adr_ld) ? adc_ld : adr_ld;

  // circle helpers
  logic [RB-1:0]   step_m1, half_m1, half_step;
  logic [SQ_W-1:0] sq_x_dec, sq_i_inc, sq_x_step;
  logic [CB-1:0]   outer_x, outer_len, radius_ext, step_ext, half_ext, hs_ext;
  logic            circ_over, half_nz, step_shrink;

  assign step_m1    = step_q - RB'(1'b1);
  assign half_m1    = half_q - RB'(1'b1);
  assign half_nz    = half_q != '0;
  assign circ_over  = ({1'b0, sq_i_q} + {1'b0, sq_x_q}) > sqlim_q;
  assign sq_x_dec   = sq_x_q - SQ_W'({half_q, 1'b0}) + SQ_W'(1'b1);
  assign sq_i_inc   = sq_i_q + SQ_W'({step_q, 1'b0}) + SQ_W'(1'b1);
  assign step_shrink = circ_over && half_nz;
  assign half_step  = step_shrink ? half_m1 : half_q;
  assign sq_x_step  = step_shrink ? sq_x_dec : sq_x_q;
  assign outer_x    = pos_col_q - CB'(step_m1);
  assign outer_len  = CB'({step_m1, 1'b0});
  assign radius_ext = CB'(radius_q);
  assign step_ext   = CB'(step_q);
  assign half_ext   = CB'(half_q);
  assign hs_ext     = CB'(half_step);

  // line step: err + delta > distance is err > distance - delta
  logic          col_hit, row_hit;
  logic [CB-1:0] err_col_nx, err_row_nx, pos_col_nx, pos_row_nx;

  assign col_hit    = err_col_q > slack_col_q;
  assign row_hit    = err_row_q > slack_row_q;
  assign err_col_nx = col_hit ? err_col_q - slack_col_q : err_col_q + adc_q;
  assign err_row_nx = row_hit ? err_row_q - slack_row_q : err_row_q + adr_q;
  assign pos_col_nx = !col_hit ? pos_col_q :
                      (dec_col_q ? pos_col_q - CB'(1'b1) : pos_col_q + CB'(1'b1));
  assign pos_row_nx = !row_hit ? pos_row_q :
                      (dec_row_q ? pos_row_q - CB'(1'b1) : pos_row_q + CB'(1'b1));

  // next state and raw span for the accepted request
  logic stamp_done;

  always_comb begin
    active_d  = active_q;
    phase_d   = phase_q;
    pos_col_d = pos_col_q;
    pos_row_d = pos_row_q;
    err_col_d = err_col_q;
    err_row_d = err_row_q;
    adc_d     = adc_q;
    adr_d     = adr_q;
    md_d      = md_q;
    dec_col_d = dec_col_q;
    dec_row_d = dec_row_q;
    stamps_d  = stamps_q;
    step_d    = step_q;
    half_d    = half_q;
    lim_d     = lim_q;
    radius_d  = radius_q;
    rsq_d     = rsq_q;
    sq_i_d    = sq_i_q;
    sq_x_d    = sq_x_q;
    color_d   = color_q;
    nx_x       = '0;
    nx_y       = '0;
    nx_len     = '0;
    nx_last    = 1'b0;
    nx_load_ok = 1'b0;
    nx_busy    = 1'b0;
    stamp_done = 1'b0;
    if (acc) begin
      if (req_i.data.cmd == tlsg_pkg::CMD_LOAD) begin
        active_d   = ld_ok;
        nx_load_ok = ld_ok;
        nx_busy    = ld_ok;
        if (ld_ok) begin
          adc_d     = adc_ld;
          adr_d     = adr_ld;
          md_d      = md_ld;
          dec_col_d = ex < sx;
          dec_row_d = ey < sy;
          stamps_d  = (CB + 1)'(md_ld) + (CB + 1)'(2);
          pos_col_d = sx;
          pos_row_d = sy;
          err_col_d = '0;
          err_row_d = '0;
          radius_d  = r_in;
          color_d   = req_i.data.pen_color;
          lim_d     = RB'(tlsg_pkg::LIMIT_TABLE[8'(r_in)]);
          rsq_d     = SQ_W'(r_in) * SQ_W'(r_in);
          phase_d   = tlsg_pkg::PH_CENTRE;
        end
      end else if (active_q) begin
        case (phase_q)
          // centre row of the stamp
          tlsg_pkg::PH_CENTRE: begin
            nx_x    = pos_col_q - radius_ext;
            nx_y    = pos_row_q;
            nx_len  = CB'({radius_q, 1'b0});
            half_d  = radius_q;
            sq_x_d  = rsq_q;
            step_d  = RB'(1'b1);
            sq_i_d  = SQ_W'(1'b1);
            phase_d = tlsg_pkg::PH_STEP;
          end
          // outer row below, or shrink and inner row below
          tlsg_pkg::PH_STEP: begin
            if (circ_over && (half_q > lim_q)) begin
              nx_x    = outer_x;
              nx_y    = pos_row_q + half_ext;
              nx_len  = outer_len;
              phase_d = tlsg_pkg::PH_OUTER_DN;
            end else begin
              half_d  = half_step;
              sq_x_d  = sq_x_step;
              nx_x    = pos_col_q - hs_ext;
              nx_y    = pos_row_q + step_ext;
              nx_len  = CB'({half_step, 1'b0});
              phase_d = tlsg_pkg::PH_INNER_DN;
            end
          end
          // outer row above, then shrink the half width
          tlsg_pkg::PH_OUTER_DN: begin
            nx_x   = outer_x;
            nx_y   = pos_row_q - half_ext;
            nx_len = outer_len;
            if (half_nz) begin
              half_d = half_m1;
              sq_x_d = sq_x_dec;
            end
            phase_d = tlsg_pkg::PH_INNER_UP;
          end
          tlsg_pkg::PH_INNER_UP: begin
            nx_x    = pos_col_q - half_ext;
            nx_y    = pos_row_q + step_ext;
            nx_len  = CB'({half_q, 1'b0});
            phase_d = tlsg_pkg::PH_INNER_DN;
          end
          // inner row above, then next step or end of stamp
          tlsg_pkg::PH_INNER_DN: begin
            nx_x   = pos_col_q - half_ext;
            nx_y   = pos_row_q - step_ext;
            nx_len = CB'({half_q, 1'b0});
            if (step_q >= lim_q) begin
              stamp_done = 1'b1;
              phase_d    = tlsg_pkg::PH_CENTRE;
            end else begin
              step_d  = step_q + RB'(1'b1);
              sq_i_d  = sq_i_inc;
              phase_d = tlsg_pkg::PH_STEP;
            end
          end
          default: begin
            phase_d = tlsg_pkg::PH_CENTRE;
          end
        endcase
        // move the brush one position along the line
        if (stamp_done) begin
          err_col_d = err_col_nx;
          err_row_d = err_row_nx;
          pos_col_d = pos_col_nx;
          pos_row_d = pos_row_nx;
          stamps_d  = stamps_q - (CB + 1)'(1'b1);
          if (stamps_q == (CB + 1)'(1'b1)) begin
            active_d = 1'b0;
            nx_last  = 1'b1;
          end
        end
        nx_busy = active_d;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      phase_q  <= tlsg_pkg::PH_CENTRE;
    end else begin
      active_q <= active_d;
      phase_q  <= phase_d;
    end
  end

  // walk payload; slack and square limit are registered from the loaded values,
  // still before the first step that reads them
  always_ff @(posedge clk_i) begin
    pos_col_q   <= pos_col_d;
    pos_row_q   <= pos_row_d;
    err_col_q   <= err_col_d;
    err_row_q   <= err_row_d;
    adc_q       <= adc_d;
    adr_q       <= adr_d;
    md_q        <= md_d;
    dec_col_q   <= dec_col_d;
    dec_row_q   <= dec_row_d;
    stamps_q    <= stamps_d;
    step_q      <= step_d;
    half_q      <= half_d;
    lim_q       <= lim_d;
    radius_q    <= radius_d;
    rsq_q       <= rsq_d;
    sq_i_q      <= sq_i_d;
    sq_x_q      <= sq_x_d;
    color_q     <= color_d;
    slack_col_q <= md_q - adc_q;
    slack_row_q <= md_q - adr_q;
    sqlim_q     <= {1'b0, rsq_q} + (SQ_W + 1)'(radius_q >> 1);
  end

  // first stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (acc) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_x_q       <= nx_x;
      s1_y_q       <= nx_y;
      s1_len_q     <= nx_len;
      s1_color_q   <= color_d;
      s1_last_q    <= nx_last;
      s1_load_ok_q <= nx_load_ok;
      s1_busy_q    <= nx_busy;
    end
  end

  // clamp to the screen
  logic [CB:0]   end_col;
  logic          over_w, over_h, span_on;
  logic [CB-1:0] left_c, right_c, row_c;

  assign span_on = s1_len_q != '0;
  assign end_col = {1'b0, s1_x_q} + {1'b0, s1_len_q} - (CB + 1)'(1'b1);
  assign over_w  = (CW + 1)'(end_col) >= {1'b0, width_q};
  assign over_h  = CW'(s1_y_q) >= height_q;
  assign left_c  = over_w ? CB'(width_q - CW'(s1_len_q) - CW'(1'b1)) : s1_x_q;
  assign right_c = over_w ? CB'(width_q - CW'(2)) : end_col[CB-1:0];
  assign row_c   = over_h ? CB'(height_q - CW'(1'b1)) : s1_y_q;

  always_comb begin
    out_d = '0;
    out_d.last_span     = s1_last_q;
    out_d.load_accepted = s1_load_ok_q;
    out_d.busy_res      = s1_busy_q;
    if (span_on) begin
      out_d.span_valid = 1'b1;
      out_d.span_left  = tlsg_pkg::FIELD_W'(left_c);
      out_d.span_right = tlsg_pkg::FIELD_W'(right_c);
      out_d.span_row   = tlsg_pkg::FIELD_W'(row_c);
      out_d.span_color = s1_color_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  // register port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= tlsg_pkg::SCREEN_WIDTH_RST;
      height_q <= tlsg_pkg::SCREEN_HEIGHT_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[tlsg_pkg::REG_SEL_BIT])
        tlsg_pkg::REG_SCREEN_WIDTH: begin
          width_q <= pwdata[CW-1:0];
        end
        tlsg_pkg::REG_SCREEN_HEIGHT: begin
          height_q <= pwdata[CW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[tlsg_pkg::REG_SEL_BIT])
      tlsg_pkg::REG_SCREEN_WIDTH:  prdata = tlsg_pkg::APB_DATA_W'(width_q);
      tlsg_pkg::REG_SCREEN_HEIGHT: prdata = tlsg_pkg::APB_DATA_W'(height_q);
      default:                     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/tlsg_checker.sv -----
`default_nettype none

module tlsg_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                req_ready_i,
  input  logic                res_valid_i,
  input  logic                res_ready_i,
  input  tlsg_pkg::tlsg_res_t res_data_i
);

  // a stalled result keeps its value
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i))
    else $error("result changed while stalled");

  // with nothing waiting at the output a request is always taken
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_i |-> req_ready_i)
    else $error("request refused with empty output");

  // every accepted request is followed by a valid result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |-> ##2 res_valid_i)
    else $error("no result two cycles after request");

endmodule

bind thick_line_span_generator tlsg_checker u_tlsg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data)
);

`default_nettype wire

// ----- dv/testbench.sv -----
module testbench;
  import tlsg_pkg::*;

  localparam int unsigned PHASE_ITEMS = 138;
  localparam int unsigned NUM_PHASES  = 8;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned MAX_PRINTS  = 50;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  tlsg_req_if req_ch ();
  tlsg_res_if res_ch ();

  thick_line_span_generator i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch),
    .res_o   (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // pending requests and expected spans
  tlsg_req_t   req_q[$];
  tlsg_res_t   span_q[$];
  int unsigned items_sent;
  int unsigned err_count;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // screen size as last written
  logic [15:0] scr_w_q;
  logic [15:0] scr_h_q;

  // line walk state of the predictor
  logic [15:0] walk_col, walk_row;
  logic [15:0] dist_col, dist_row;
  logic [15:0] step_col, step_row;
  logic [15:0] major_len;
  int unsigned acc_col, acc_row, stamps_todo;
  int unsigned ring_i, ring_x, ring_lim, ring_sq;
  phase_e      span_ph;
  logic [7:0]  brush_r;
  logic [15:0] ink;
  logic        line_on;

  // clock and known input values from the start
  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    req_ch.valid   = 1'b0;
    req_ch.data    = '0;
    res_ch.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // clamp one span to the screen, zero-length spans are not valid
  function automatic tlsg_res_t clip_span(int unsigned x0, int unsigned y0, int unsigned len);
    tlsg_res_t   s;
    int unsigned cx, cy, l;
    s  = '0;
    cx = x0 & 32'hFFFF;
    cy = y0 & 32'hFFFF;
    l  = len & 32'hFFFF;
    if (l != 0) begin
      if (cx + l - 1 >= scr_w_q) cx = (scr_w_q - l - 1) & 32'hFFFF;
      if (cy >= scr_h_q) cy = (scr_h_q - 1) & 32'hFFFF;
      s.span_valid = 1'b1;
      s.span_left  = 16'(cx);
      s.span_right = 16'(cx + l - 1);
      s.span_row   = 16'(cy);
      s.span_color = ink;
    end
    return s;
  endfunction

  // next result of the span generator for one request
  function automatic tlsg_res_t predict_span(tlsg_req_t rq);
    tlsg_res_t   o;
    int unsigned x0, y0, r, i, x, lim;
    logic        wide, done;
    o = '0;
    if (rq.cmd == CMD_LOAD) begin
      line_on = 1'b0;
      r = rq.brush_radius;
      if (rq.start_x >= r && rq.start_y >= r && rq.end_x >= r && rq.end_y >= r) begin
        dist_col = rq.end_x > rq.start_x ? rq.end_x - rq.start_x : rq.start_x - rq.end_x;
        dist_row = rq.end_y > rq.start_y ? rq.end_y - rq.start_y : rq.start_y - rq.end_y;
        step_col = rq.end_x > rq.start_x ? 16'h0001 :
                   (rq.end_x < rq.start_x ? 16'hFFFF : 16'h0000);
        step_row = rq.end_y > rq.start_y ? 16'h0001 :
                   (rq.end_y < rq.start_y ? 16'hFFFF : 16'h0000);
        major_len   = dist_col > dist_row ? dist_col : dist_row;
        stamps_todo = major_len + 2;
        walk_col    = rq.start_x;
        walk_row    = rq.start_y;
        acc_col     = 0;
        acc_row     = 0;
        brush_r     = rq.brush_radius;
        ink         = rq.pen_color;
        ring_lim    = r * LimitNum / LimitDen + 1;
        ring_sq     = r * r + r / 2;
        ring_i      = 0;
        ring_x      = r;
        span_ph     = PH_CENTRE;
        line_on     = 1'b1;
        o.load_accepted = 1'b1;
      end
      o.busy_res = line_on;
    end else if (line_on) begin
      x0   = walk_col;
      y0   = walk_row;
      r    = brush_r;
      i    = ring_i;
      x    = ring_x;
      lim  = ring_lim;
      done = 1'b0;
      case (span_ph)
        PH_CENTRE: begin
          o       = clip_span(x0 - r, y0, 2 * r);
          ring_x  = r;
          ring_i  = 1;
          span_ph = PH_STEP;
        end
        PH_STEP: begin
          wide = (i * i + x * x > ring_sq);
          if (wide && x > lim) begin
            // outer row below, its mirror follows
            o       = clip_span(x0 - i + 1, y0 + x, 2 * (i - 1));
            span_ph = PH_OUTER_DN;
          end else begin
            if (wide && x > 0) x--;
            ring_x  = x;
            o       = clip_span(x0 - x, y0 + i, 2 * x);
            span_ph = PH_INNER_DN;
          end
        end
        PH_OUTER_DN: begin
          o       = clip_span(x0 - i + 1, y0 - x, 2 * (i - 1));
          ring_x  = x > 0 ? x - 1 : 0;
          span_ph = PH_INNER_UP;
        end
        PH_INNER_UP: begin
          o       = clip_span(x0 - x, y0 + i, 2 * x);
          span_ph = PH_INNER_DN;
        end
        default: begin
          o = clip_span(x0 - x, y0 - i, 2 * x);
          if (i >= lim) begin
            done = 1'b1;
          end else begin
            ring_i  = i + 1;
            span_ph = PH_STEP;
          end
        end
      endcase
      // bresenham step once a stamp is complete
      if (done) begin
        acc_col += dist_col;
        acc_row += dist_row;
        if (acc_col > major_len) begin
          acc_col -= major_len;
          walk_col += step_col;
        end
        if (acc_row > major_len) begin
          acc_row -= major_len;
          walk_row += step_row;
        end
        stamps_todo = stamps_todo > 0 ? stamps_todo - 1 : 0;
        span_ph = PH_CENTRE;
        if (stamps_todo == 0) begin
          line_on     = 1'b0;
          o.last_span = 1'b1;
        end
      end
      o.busy_res = line_on;
    end
    return o;
  endfunction

  // number of spans one circle stamp gives
  function automatic int unsigned ticks_per_stamp(int unsigned r);
    int unsigned n, x, lim, sq;
    n   = 1;
    x   = r;
    lim = r * LimitNum / LimitDen + 1;
    sq  = r * r + r / 2;
    for (int unsigned i = 1; i <= lim; i++) begin
      if (i * i + x * x > sq && x > lim) begin
        n += 4;
        x--;
      end else begin
        if (i * i + x * x > sq && x > 0) x--;
        n += 2;
      end
    end
    return n;
  endfunction

  function automatic int unsigned pick_coord(int unsigned r);
    case ($urandom_range(2))
      0: return r + $urandom_range(15);
      1: return 65535 - $urandom_range(15);
      default: return $urandom_range(65535, r);
    endcase
  endfunction

  // end point within d of s that stays in the legal range
  function automatic int unsigned pick_end(int unsigned s, int unsigned r, int unsigned d);
    int e, delta;
    delta = $urandom_range(d);
    e = $urandom_range(1) ? int'(s) + delta : int'(s) - delta;
    if (e > 65535 || e < int'(r)) e = 2 * int'(s) - e;
    return e;
  endfunction

  task automatic push_load(input int unsigned sx, input int unsigned sy, input int unsigned ex,
                           input int unsigned ey, input int unsigned r, input int unsigned col);
    tlsg_req_t rq;
    rq.cmd          = CMD_LOAD;
    rq.start_x      = 16'(sx);
    rq.start_y      = 16'(sy);
    rq.end_x        = 16'(ex);
    rq.end_y        = 16'(ey);
    rq.brush_radius = 8'(r);
    rq.pen_color    = 16'(col);
    req_q.push_back(rq);
    items_sent++;
  endtask

  // ticks carry random payload, which the block ignores
  task automatic push_tick(input int unsigned n);
    tlsg_req_t rq;
    repeat (n) begin
      rq.cmd          = CMD_TICK;
      rq.start_x      = 16'($urandom);
      rq.start_y      = 16'($urandom);
      rq.end_x        = 16'($urandom);
      rq.end_y        = 16'($urandom);
      rq.brush_radius = 8'($urandom);
      rq.pen_color    = 16'($urandom);
      req_q.push_back(rq);
      items_sent++;
    end
  endtask

  // short well-formed line, mostly run to its last span
  task automatic push_line();
    int unsigned r, d, sx, sy, ex, ey, dx, dy, span_cnt;
    r  = ($urandom_range(15) == 0) ? $urandom_range(255) : $urandom_range(6);
    d  = ($urandom_range(7) == 0) ? $urandom_range(12) : $urandom_range(3);
    sx = pick_coord(r);
    sy = pick_coord(r);
    ex = pick_end(sx, r, d);
    ey = pick_end(sy, r, d);
    dx = ex > sx ? ex - sx : sx - ex;
    dy = ey > sy ? ey - sy : sy - ey;
    span_cnt = ((dx > dy ? dx : dy) + 2) * ticks_per_stamp(r);
    push_load(sx, sy, ex, ey, r, $urandom_range(65535));
    if (span_cnt > 120 || $urandom_range(4) == 0)
      push_tick($urandom_range(span_cnt - 1 < 60 ? span_cnt - 1 : 60));
    else
      push_tick(span_cnt + $urandom_range(2));
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(idx) << REG_SEL_BIT;
    pwdata  <= APB_DATA_W'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_SCREEN_WIDTH) scr_w_q = val;
    else scr_h_q = val;
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req_ch.valid <= 1'b1;
        req_ch.data  <= req_q.pop_front();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(posedge clk_i) begin
    if (!rst_ni) res_ch.ready <= 1'b0;
    else res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // predict on every accepted request
  always @(posedge clk_i) begin
    if (rst_ni && req_ch.valid && req_ch.ready) span_q.push_back(predict_span(req_ch.data));
  end

  // compare accepted results with the oldest expected span
  always @(posedge clk_i) begin
    tlsg_res_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (span_q.size() == 0) begin
        report_mismatch("result arrived with nothing expected");
      end else begin
        want = span_q.pop_front();
        check_field("span_valid", res_ch.data.span_valid, want.span_valid);
        check_field("span_left", res_ch.data.span_left, want.span_left);
        check_field("span_right", res_ch.data.span_right, want.span_right);
        check_field("span_row", res_ch.data.span_row, want.span_row);
        check_field("span_color", res_ch.data.span_color, want.span_color);
        check_field("last_span", res_ch.data.last_span, want.last_span);
        check_field("load_accepted", res_ch.data.load_accepted, want.load_accepted);
        check_field("busy_res", res_ch.data.busy_res, want.busy_res);
      end
    end
  end

  // watchdog on cycles without progress while work is pending
  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (req_q.size() == 0 && !req_ch.valid && span_q.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus, one screen setting and idling mode per phase
  initial begin
    int unsigned r;
    int unsigned c[4];
    int unsigned pick;
    items_sent   = 0;
    err_count    = 0;
    quiet_cycles = 0;
    scr_w_q      = SCREEN_WIDTH_RST;
    scr_h_q      = SCREEN_HEIGHT_RST;
    line_on      = 1'b0;
    span_ph      = PH_CENTRE;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // screen size, written while the block is idle
      case (ph)
        1: begin
          write_reg(REG_SCREEN_WIDTH, 16'd1);
          write_reg(REG_SCREEN_HEIGHT, 16'd1);
        end
        2: begin
          write_reg(REG_SCREEN_WIDTH, 16'd65535);
          write_reg(REG_SCREEN_HEIGHT, 16'd65535);
        end
        3: begin
          write_reg(REG_SCREEN_WIDTH, 16'd64);
          write_reg(REG_SCREEN_HEIGHT, 16'd48);
        end
        5: begin
          write_reg(REG_SCREEN_WIDTH, SCREEN_WIDTH_RST);
          write_reg(REG_SCREEN_HEIGHT, SCREEN_HEIGHT_RST);
        end
        6: begin
          write_reg(REG_SCREEN_WIDTH, 16'd2);
          write_reg(REG_SCREEN_HEIGHT, 16'd65535);
        end
        4, 7: begin
          write_reg(REG_SCREEN_WIDTH, 16'($urandom_range(65535, 1)));
          write_reg(REG_SCREEN_HEIGHT, 16'($urandom_range(65535, 1)));
        end
        default: ;
      endcase

      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase

      if (ph == 0) begin
        // tick with no line loaded
        push_tick(1);
        // zero radius at the origin, all spans empty
        push_load(0, 0, 0, 0, 0, 16'hFFFF);
        push_tick(2 * ticks_per_stamp(0));
        // coordinate below the radius
        push_load(4, 10, 10, 10, 5, 16'h1234);
        push_tick(1);
        // one stamp at the far corner with outer rows, clamped and wrapped
        push_load(65535, 65535, 65535, 65535, 4, 16'h0000);
        push_tick(ticks_per_stamp(4));
        // widest brush, then a load that drops it
        push_load(255, 65535, 65535, 255, 255, 16'hA5A5);
        push_tick(3);
        push_load(300, 300, 310, 290, 255, 16'h5A5A);
      end

      while (items_sent < (ph + 1) * PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          push_line();
        end else if (pick < 85) begin
          // fully random load, usually a long line that gets cut
          push_load($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                    $urandom_range(65535), $urandom_range(255), $urandom_range(65535));
          push_tick($urandom_range(20));
        end else begin
          // one coordinate below the radius
          r = $urandom_range(255, 1);
          foreach (c[k]) c[k] = pick_coord(r);
          c[$urandom_range(3)] = $urandom_range(r - 1);
          push_load(c[0], c[1], c[2], c[3], r, $urandom_range(65535));
          push_tick($urandom_range(3));
        end
      end

      // drain before the next setting
      while (req_q.size() != 0 || req_ch.valid || span_q.size() != 0) @(posedge clk_i);
      repeat (4) @(posedge clk_i);
    end

    if (err_count == 0 && span_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/tlsg_pkg.sv
rtl/tlsg_if.sv
rtl/thick_line_span_generator.sv
rtl/tlsg_checker.sv
dv/testbench.sv
